FILE: design/grc_pkg.sv
`default_nettype none
package grc_pkg;

  localparam int MAP_DIM     = 8;
  localparam int MAP_BITS    = $clog2(MAP_DIM);
  localparam int TILE_SHIFT  = 12;
  localparam int NUM_RAYS    = 60;
  localparam int RAY_W       = $clog2(NUM_RAYS);
  localparam int MAX_STEPS   = 8;
  localparam int COR_STEPS   = 16;
  localparam int DIV_BITS    = 34;
  localparam int SCREEN_H    = 320;
  localparam int HEIGHT_NUM  = 64 * SCREEN_H * 64;
  localparam int HEIGHT_LIM  = HEIGHT_NUM / SCREEN_H;
  localparam int CORDIC_X0   = 39797;
  localparam logic [63:0] MAP_RESET = 64'd18411139282397136383;

  function automatic logic [15:0] ray_off(input int n);
    return 16'((n * 65536 + 180) / 360);
  endfunction

  typedef logic [NUM_RAYS-1:0][15:0] ray_tab_t;

  function automatic ray_tab_t make_ray_tab();
    ray_tab_t t;
    for (int n = 0; n < NUM_RAYS; n++) begin
      t[n] = ray_off(n);
    end
    return t;
  endfunction

  localparam ray_tab_t RAY_OFF = make_ray_tab();
  localparam logic [15:0] HALF_OFF = ray_off(NUM_RAYS / 2);

  function automatic logic signed [24:0] atan_f(input logic [3:0] i);
    logic signed [24:0] v;
    unique case (i)
      4'd0:  v = 25'sd2097152;
      4'd1:  v = 25'sd1238021;
      4'd2:  v = 25'sd654136;
      4'd3:  v = 25'sd332050;
      4'd4:  v = 25'sd166669;
      4'd5:  v = 25'sd83416;
      4'd6:  v = 25'sd41718;
      4'd7:  v = 25'sd20860;
      4'd8:  v = 25'sd10430;
      4'd9:  v = 25'sd5215;
      4'd10: v = 25'sd2608;
      4'd11: v = 25'sd1304;
      4'd12: v = 25'sd652;
      4'd13: v = 25'sd326;
      4'd14: v = 25'sd163;
      4'd15: v = 25'sd81;
    endcase
    return v;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_VCOR, ST_VSAVE, ST_RSTART, ST_RCOR, ST_RSAVE, ST_AXIS,
    ST_SMUL, ST_SDIV0, ST_SDIV, ST_SCHK, ST_D2, ST_PICK, ST_PROJ, ST_DIST,
    ST_HDIV0, ST_HDIV, ST_HSET, ST_EMIT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_COR_STEP, OP_SAVE_VIEW, OP_RAY_START, OP_SAVE_RAY,
    OP_STEP_MUL, OP_STEP_DIV_START, OP_DIV_STEP, OP_STEP_CHK, OP_D2, OP_PICK,
    OP_PROJ, OP_DIST, OP_HGT_DIV_START, OP_HGT_SET, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [3:0]       idx;
    logic             axis;
    logic [RAY_W-1:0] ray;
  } dp_cmd_t;

  typedef struct packed {
    logic dmain_zero;
    logic wall;
    logic d_small;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/grc_ifs.sv
`default_nettype none
interface grc_frame_if;
  logic        valid;
  logic        ready;
  logic [14:0] pos_x;
  logic [14:0] pos_y;
  logic [15:0] view_angle;
  modport source (output valid, pos_x, pos_y, view_angle, input ready);
  modport sink (input valid, pos_x, pos_y, view_angle, output ready);
endinterface

interface grc_ray_if;
  logic        valid;
  logic        ready;
  logic [5:0]  column;
  logic [8:0]  wall_height;
  logic [7:0]  wall_top;
  logic [15:0] distance;
  logic [14:0] hit_x;
  logic [14:0] hit_y;
  logic        hit_vertical;
  logic        no_hit;
  logic        last;
  modport source (output valid, column, wall_height, wall_top, distance, hit_x, hit_y,
                  hit_vertical, no_hit, last, input ready);
  modport sink (input valid, column, wall_height, wall_top, distance, hit_x, hit_y,
                hit_vertical, no_hit, last, output ready);
endinterface
`default_nettype wire

FILE: design/grid_raycast_column_heights_top.sv
`default_nettype none
// Channel  Dir  Word
// frame    in   pos_x, pos_y, view_angle (one frame request)
// ray      out  column, wall_height, wall_top, distance, hit_x, hit_y, hit_vertical,
//               no_hit, last (one word per ray, NUM_RAYS words per frame)
// cfg      in   cfg_we, cfg_wdata (wall bitmap)
//
// A frame runs the view-angle CORDIC and then, for each ray, the ray CORDIC, an axis
// step per axis, a multiply, divide and check for every grid crossing examined, and
// the distance and height calculation (shorter when the height saturates).
// A single restoring divider is shared by the crossing steps and the height division.
// Reset is synchronous and loads the default wall bitmap.
// A stalled ray word holds the block in its emit step; the next frame is taken
// once the last ray word has been registered.
module grid_raycast_column_heights_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  grc_frame_if.sink    frame,
  grc_ray_if.source    ray
);
  import grc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (frame.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  grc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pos_x        (frame.pos_x),
    .pos_y        (frame.pos_y),
    .view_angle   (frame.view_angle),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (ray.valid),
    .out_ready    (ray.ready),
    .column       (ray.column),
    .wall_height  (ray.wall_height),
    .wall_top     (ray.wall_top),
    .distance     (ray.distance),
    .hit_x        (ray.hit_x),
    .hit_y        (ray.hit_y),
    .hit_vertical (ray.hit_vertical),
    .no_hit       (ray.no_hit),
    .last         (ray.last)
  );

endmodule
`default_nettype wire

FILE: design/grc_ctrl.sv
`default_nettype none
module grc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output grc_pkg::dp_cmd_t  cmd,
  input  grc_pkg::dp_stat_t stat
);
  import grc_pkg::*;

  ctl_state_t       state, state_next;
  logic [5:0]       cnt, cnt_next;
  logic [3:0]       k, k_next;
  logic [RAY_W-1:0] ray, ray_next;
  logic             axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      k     <= '0;
      ray   <= '0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      ray   <= ray_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    ray_next   = ray;
    axis_next  = axis;
    in_ready   = 1'b0;
    cmd.op     = OP_NOP;
    cmd.idx    = cnt[3:0];
    cmd.axis   = axis;
    cmd.ray    = ray;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          cnt_next   = '0;
          state_next = ST_VCOR;
        end
      end
      ST_VCOR, ST_RCOR: begin
        cmd.op   = OP_COR_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(COR_STEPS - 1)) begin
          state_next = (state == ST_VCOR) ? ST_VSAVE : ST_RSAVE;
        end
      end
      ST_VSAVE: begin
        cmd.op     = OP_SAVE_VIEW;
        ray_next   = '0;
        state_next = ST_RSTART;
      end
      ST_RSTART: begin
        cmd.op     = OP_RAY_START;
        cnt_next   = '0;
        state_next = ST_RCOR;
      end
      ST_RSAVE: begin
        cmd.op     = OP_SAVE_RAY;
        axis_next  = 1'b0;
        state_next = ST_AXIS;
      end
      ST_AXIS: begin
        k_next = '0;
        if (!stat.dmain_zero) begin
          state_next = ST_SMUL;
        end else if (!axis) begin
          axis_next = 1'b1;
        end else begin
          cnt_next   = '0;
          state_next = ST_D2;
        end
      end
      ST_SMUL: begin
        cmd.op     = OP_STEP_MUL;
        cmd.idx    = k;
        state_next = ST_SDIV0;
      end
      ST_SDIV0: begin
        cmd.op     = OP_STEP_DIV_START;
        cmd.idx    = k;
        cnt_next   = '0;
        state_next = ST_SDIV;
      end
      ST_SDIV, ST_HDIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(DIV_BITS - 1)) begin
          state_next = (state == ST_SDIV) ? ST_SCHK : ST_HSET;
        end
      end
      ST_SCHK: begin
        cmd.op  = OP_STEP_CHK;
        cmd.idx = k;
        if (stat.wall || k == 4'(MAX_STEPS - 1)) begin
          if (!axis) begin
            axis_next  = 1'b1;
            state_next = ST_AXIS;
          end else begin
            cnt_next   = '0;
            state_next = ST_D2;
          end
        end else begin
          k_next     = k + 4'd1;
          state_next = ST_SMUL;
        end
      end
      ST_D2: begin
        cmd.op   = OP_D2;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd4) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.op     = OP_PICK;
        cnt_next   = '0;
        state_next = ST_PROJ;
      end
      ST_PROJ: begin
        cmd.op   = OP_PROJ;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd2) begin
          state_next = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd.op     = OP_DIST;
        state_next = ST_HDIV0;
      end
      ST_HDIV0: begin
        cmd.op     = OP_HGT_DIV_START;
        cnt_next   = '0;
        state_next = stat.d_small ? ST_HSET : ST_HDIV;
      end
      ST_HSET: begin
        cmd.op     = OP_HGT_SET;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op = OP_EMIT;
          if (ray == RAY_W'(NUM_RAYS - 1)) begin
            state_next = ST_IDLE;
          end else begin
            ray_next   = ray + 1'b1;
            state_next = ST_RSTART;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/grc_datapath.sv
`default_nettype none
module grc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [63:0]       cfg_wdata,
  input  logic [14:0]       pos_x,
  input  logic [14:0]       pos_y,
  input  logic [15:0]       view_angle,
  input  grc_pkg::dp_cmd_t  cmd,
  output grc_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        column,
  output logic [8:0]        wall_height,
  output logic [7:0]        wall_top,
  output logic [15:0]       distance,
  output logic [14:0]       hit_x,
  output logic [14:0]       hit_y,
  output logic              hit_vertical,
  output logic              no_hit,
  output logic              last
);
  import grc_pkg::*;

  logic [63:0]        wall_map;
  logic [14:0]        px, py;
  logic [15:0]        va;
  logic signed [18:0] cx, cy;
  logic signed [24:0] cz;
  logic               cflip, cspec;
  logic [1:0]         cquad;
  logic signed [17:0] cv, sv, rc, rs;
  logic               found_h, found_v;
  logic [15:0]        hx, hy, vx, vy, bx, by;
  logic signed [37:0] prod, acc, d2h;
  logic [16:0]        div_rem, div_d;
  logic [DIV_BITS-1:0] div_quo;
  logic               div_neg;
  logic               sel_v;
  logic [16:0]        proj_dist;
  logic [8:0]         height;

  logic [15:0]        cor_ang, ray_ang;
  logic signed [24:0] z0, zf;
  logic               f0;
  logic signed [18:0] xs, ys;
  logic signed [24:0] at;
  logic signed [18:0] nx, ny;
  logic signed [17:0] cor_c, cor_s;

  logic [14:0]        pm, pc;
  logic signed [17:0] dmn, dcr;
  logic               neg;
  logic [2:0]         base;
  logic signed [6:0]  line, cell_main;
  logic signed [19:0] m, diff;
  logic signed [35:0] qv, cr;
  logic               main_ok, cross_ok, wall;
  logic [MAP_BITS-1:0] row, col;

  logic signed [17:0] dxh, dyh, dxv, dyv, dx, dy;
  logic signed [19:0] ma;
  logic signed [17:0] mb;
  logic [17:0]        rem_sh;
  logic               ge;
  logic signed [37:0] pabs;
  logic signed [17:0] dabs;

  assign ray_ang = va - HALF_OFF + RAY_OFF[cmd.ray];
  assign cor_ang = (cmd.op == OP_LOAD) ? view_angle : ray_ang;

  always_comb begin
    z0 = signed'({cor_ang[15], cor_ang, 8'b0});
    zf = z0;
    f0 = 1'b0;
    if (z0 > 25'sd4194304) begin
      zf = z0 - 25'sd8388608;
      f0 = 1'b1;
    end else if (z0 < -25'sd4194304) begin
      zf = z0 + 25'sd8388608;
      f0 = 1'b1;
    end
  end

  assign xs = cx >>> cmd.idx;
  assign ys = cy >>> cmd.idx;
  assign at = atan_f(cmd.idx);
  assign nx = -cx;
  assign ny = -cy;

  always_comb begin
    if (cspec) begin
      cor_c = (cquad == 2'd0) ? 18'sd65536 : ((cquad == 2'd2) ? -18'sd65536 : 18'sd0);
      cor_s = (cquad == 2'd1) ? 18'sd65536 : ((cquad == 2'd3) ? -18'sd65536 : 18'sd0);
    end else begin
      cor_c = cflip ? nx[17:0] : cx[17:0];
      cor_s = cflip ? ny[17:0] : cy[17:0];
    end
  end

  assign pm   = cmd.axis ? px : py;
  assign pc   = cmd.axis ? py : px;
  assign dmn  = cmd.axis ? rc : rs;
  assign dcr  = cmd.axis ? rs : rc;
  assign neg  = dmn[17];
  assign base = pm[14:TILE_SHIFT];

  always_comb begin
    if (neg) begin
      line = signed'({4'b0, base}) - signed'({3'b0, cmd.idx});
    end else begin
      line = signed'({4'b0, base}) + 7'sd1 + signed'({3'b0, cmd.idx});
    end
    m         = 20'(signed'({line, {TILE_SHIFT{1'b0}}}));
    diff      = m - signed'({5'b0, pm});
    cell_main = line - signed'({6'b0, neg});
    main_ok   = !cell_main[6] && (cell_main < 7'(MAP_DIM));
    qv        = signed'({{(36 - DIV_BITS){1'b0}}, div_quo});
    cr        = (div_neg ? -qv : qv) + signed'({21'b0, pc});
    cross_ok  = !cr[35] && (cr < 36'(MAP_DIM << TILE_SHIFT));
    if (cmd.axis) begin
      row = cr[TILE_SHIFT +: MAP_BITS];
      col = cell_main[MAP_BITS-1:0];
    end else begin
      row = cell_main[MAP_BITS-1:0];
      col = cr[TILE_SHIFT +: MAP_BITS];
    end
    wall = main_ok && cross_ok && wall_map[6'(row * MAP_DIM + col)];
  end

  assign dxh = signed'({2'b0, hx}) - signed'({3'b0, px});
  assign dyh = signed'({2'b0, hy}) - signed'({3'b0, py});
  assign dxv = signed'({2'b0, vx}) - signed'({3'b0, px});
  assign dyv = signed'({2'b0, vy}) - signed'({3'b0, py});
  assign dx  = signed'({2'b0, bx}) - signed'({3'b0, px});
  assign dy  = signed'({2'b0, by}) - signed'({3'b0, py});

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_STEP_MUL: begin
        ma = diff;
        mb = dcr;
      end
      OP_D2: begin
        unique case (cmd.idx[1:0])
          2'd0: begin ma = 20'(dxh); mb = dxh; end
          2'd1: begin ma = 20'(dyh); mb = dyh; end
          2'd2: begin ma = 20'(dxv); mb = dxv; end
          2'd3: begin ma = 20'(dyv); mb = dyv; end
        endcase
      end
      OP_PROJ: begin
        if (cmd.idx == 4'd0) begin
          ma = 20'(dx);
          mb = cv;
        end else begin
          ma = 20'(dy);
          mb = sv;
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rem_sh = {div_rem, div_quo[DIV_BITS-1]};
  assign ge     = rem_sh >= {1'b0, div_d};
  assign pabs   = prod[37] ? -prod : prod;
  assign dabs   = neg ? -dmn : dmn;

  assign stat.dmain_zero = (dmn == 18'sd0);
  assign stat.wall       = wall;
  assign stat.d_small    = proj_dist <= 17'(HEIGHT_LIM);
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map <= MAP_RESET;
    end else if (cfg_we) begin
      wall_map <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      found_h   <= 1'b0;
      found_v   <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_SAVE_RAY) begin
        found_h <= 1'b0;
        found_v <= 1'b0;
      end else if (cmd.op == OP_STEP_CHK && wall) begin
        if (cmd.axis) begin
          found_v <= 1'b1;
        end else begin
          found_h <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD, OP_RAY_START: begin
        if (cmd.op == OP_LOAD) begin
          px <= pos_x;
          py <= pos_y;
          va <= view_angle;
        end
        cx    <= 19'sd39797;
        cy    <= '0;
        cz    <= zf;
        cflip <= f0;
        cspec <= (cor_ang[13:0] == 14'd0);
        cquad <= cor_ang[15:14];
      end
      OP_COR_STEP: begin
        if (!cz[24]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
      end
      OP_SAVE_VIEW: begin
        cv <= cor_c;
        sv <= cor_s;
      end
      OP_SAVE_RAY: begin
        rc <= cor_c;
        rs <= cor_s;
      end
      OP_STEP_MUL: begin
        prod <= ma * mb;
      end
      OP_STEP_DIV_START: begin
        div_rem <= '0;
        div_quo <= pabs[DIV_BITS-1:0];
        div_d   <= dabs[16:0];
        div_neg <= prod[37] ^ neg;
      end
      OP_HGT_DIV_START: begin
        div_rem <= '0;
        div_quo <= DIV_BITS'(HEIGHT_NUM);
        div_d   <= proj_dist;
        div_neg <= 1'b0;
      end
      OP_DIV_STEP: begin
        div_rem <= ge ? 17'(rem_sh - {1'b0, div_d}) : rem_sh[16:0];
        div_quo <= {div_quo[DIV_BITS-2:0], ge};
      end
      OP_STEP_CHK: begin
        if (wall) begin
          if (cmd.axis) begin
            vx <= m[15:0];
            vy <= cr[15:0];
          end else begin
            hy <= m[15:0];
            hx <= cr[15:0];
          end
        end
      end
      OP_D2: begin
        prod <= ma * mb;
        unique case (cmd.idx[2:0])
          3'd1, 3'd3: acc <= prod;
          3'd2: d2h <= acc + prod;
          3'd4: acc <= acc + prod;
          default: acc <= acc;
        endcase
      end
      OP_PICK: begin
        sel_v <= found_v && (!found_h || acc < d2h);
        if (found_v && (!found_h || acc < d2h)) begin
          bx <= vx;
          by <= vy;
        end else if (found_h) begin
          bx <= hx;
          by <= hy;
        end else begin
          bx <= {1'b0, px};
          by <= {1'b0, py};
        end
      end
      OP_PROJ: begin
        prod <= ma * mb;
        if (cmd.idx == 4'd1) begin
          acc <= prod;
        end else if (cmd.idx == 4'd2) begin
          acc <= acc + prod;
        end
      end
      OP_DIST: begin
        proj_dist <= acc[37] ? 17'd0 : acc[32:16];
      end
      OP_HGT_SET: begin
        height <= stat.d_small ? 9'(SCREEN_H) : div_quo[8:0];
      end
      OP_EMIT: begin
        column <= 6'(cmd.ray);
        last   <= (cmd.ray == RAY_W'(NUM_RAYS - 1));
        if (!found_h && !found_v) begin
          wall_height  <= '0;
          wall_top     <= 8'(SCREEN_H / 2);
          distance     <= 16'hFFFF;
          hit_x        <= '0;
          hit_y        <= '0;
          hit_vertical <= 1'b0;
          no_hit       <= 1'b1;
        end else begin
          wall_height  <= height;
          wall_top     <= 8'((9'(SCREEN_H) - height) >> 1);
          distance     <= proj_dist[16] ? 16'hFFFF : proj_dist[15:0];
          hit_x        <= bx[15] ? 15'h7FFF : bx[14:0];
          hit_y        <= by[15] ? 15'h7FFF : by[14:0];
          hit_vertical <= sel_v;
          no_hit       <= 1'b0;
        end
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: bench/grid_raycast_column_heights_top_test.sv
`default_nettype none
module grid_raycast_column_heights_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import grc_pkg::*;

  typedef struct {
    logic [5:0]  column;
    logic [8:0]  wall_height;
    logic [7:0]  wall_top;
    logic [15:0] distance;
    logic [14:0] hit_x;
    logic [14:0] hit_y;
    logic        hit_vertical;
    logic        no_hit;
    logic        last;
  } column_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  grc_frame_if frame ();
  grc_ray_if   ray ();

  grid_raycast_column_heights_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .frame     (frame.sink),
    .ray       (ray.source)
  );

  localparam int ATAN_TAB [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                   41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                   163, 81};

  logic [63:0] map_model;
  column_t     column_queue [$];
  int          fail_count = 0;
  bit          no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    frame.valid      = 1'b0;
    frame.pos_x      = '0;
    frame.pos_y      = '0;
    frame.view_angle = '0;
    ray.ready        = 1'b0;
  end

  function automatic void sine_cosine(input logic [15:0] ang, output int c, output int s);
    int x, y, z, xs, ys;
    bit flip;
    x = CORDIC_X0;
    y = 0;
    flip = 1'b0;
    if (ang[13:0] == 14'd0) begin
      c = (ang[15:14] == 2'd0) ? 65536 : ((ang[15:14] == 2'd2) ? -65536 : 0);
      s = (ang[15:14] == 2'd1) ? 65536 : ((ang[15:14] == 2'd3) ? -65536 : 0);
      return;
    end
    z = int'({ang, 8'h00});
    if (z >= 8388608) z -= 16777216;
    if (z > 4194304) begin
      z -= 8388608;
      flip = 1'b1;
    end else if (z < -4194304) begin
      z += 8388608;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit wall_at(input longint col, input longint row);
    if (col < 0 || row < 0 || col >= MAP_DIM || row >= MAP_DIM) return 1'b0;
    return map_model[row * MAP_DIM + col];
  endfunction

  function automatic bit trace_axis(input longint p_main, input longint p_cross,
                                    input longint d_main, input longint d_cross,
                                    input bit vert, output longint h_main,
                                    output longint h_cross);
    longint base, line, m, cr, cell_main, cell_cross;
    bit neg;
    h_main = 0;
    h_cross = 0;
    if (d_main == 0) return 1'b0;
    neg = d_main < 0;
    base = p_main / 4096;
    for (int k = 0; k < MAX_STEPS; k++) begin
      line = neg ? base - k : base + 1 + k;
      m = line * 4096;
      cr = p_cross + ((m - p_main) * d_cross) / d_main;
      cell_main = line - neg;
      if (cr < 0) continue;
      cell_cross = cr / 4096;
      if (vert ? wall_at(cell_main, cell_cross) : wall_at(cell_cross, cell_main)) begin
        h_main = m;
        h_cross = cr;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_columns(input logic [14:0] px_in, input logic [14:0] py_in,
                                          input logic [15:0] va);
    longint px, py, hx, hy, vx, vy, bx, by, d, h;
    int cv, sv, c, s;
    logic [15:0] ra, half;
    bit hh, hv, use_v;
    column_t e;
    px = px_in;
    py = py_in;
    half = 16'((30 * 65536 + 180) / 360);
    sine_cosine(va, cv, sv);
    for (int r = 0; r < NUM_RAYS; r++) begin
      ra = 16'(va - half + 16'((r * 65536 + 180) / 360));
      sine_cosine(ra, c, s);
      hh = trace_axis(py, px, s, c, 1'b0, hy, hx);
      hv = trace_axis(px, py, c, s, 1'b1, vx, vy);
      e.column = 6'(r);
      e.last = (r == NUM_RAYS - 1);
      if (!hh && !hv) begin
        e.wall_height = 0; e.wall_top = 160; e.distance = 16'hFFFF;
        e.hit_x = 0; e.hit_y = 0; e.hit_vertical = 0; e.no_hit = 1;
      end else begin
        if (hh && hv)
          use_v = ((vx-px)*(vx-px) + (vy-py)*(vy-py)) < ((hx-px)*(hx-px) + (hy-py)*(hy-py));
        else
          use_v = hv;
        bx = use_v ? vx : hx;
        by = use_v ? vy : hy;
        d = ((bx - px) * cv + (by - py) * sv) >>> 16;
        if (d < 0) d = 0;
        h = (d == 0) ? 320 : 1310720 / d;
        if (h > 320) h = 320;
        e.wall_height = 9'(h);
        e.wall_top = 8'((320 - h) / 2);
        e.distance = (d > 65535) ? 16'hFFFF : 16'(d);
        e.hit_x = (bx > 32767) ? 15'h7FFF : 15'(bx);
        e.hit_y = (by > 32767) ? 15'h7FFF : 15'(by);
        e.hit_vertical = use_v;
        e.no_hit = 0;
      end
      column_queue.push_back(e);
    end
  endfunction

  task automatic send_frame(input logic [14:0] px, input logic [14:0] py,
                            input logic [15:0] va);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      frame.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame.valid <= 1'b1;
    frame.pos_x <= px;
    frame.pos_y <= py;
    frame.view_angle <= va;
    do @(posedge clk); while (!frame.ready);
    predict_columns(px, py, va);
  endtask

  task automatic write_map(input logic [63:0] value);
    frame.valid <= 1'b0;
    wait (column_queue.size() == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    map_model = value;
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        ray.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      ray.ready <= 1'b1;
      do @(posedge clk); while (!ray.valid);
    end
  end

  always @(posedge clk) begin
    column_t e;
    if (!rst && ray.valid && ray.ready) begin
      if (column_queue.size() == 0) begin
        $error("ray word with no expectation: column %0d", ray.column);
        fail_count++;
      end else begin
        e = column_queue.pop_front();
        if (ray.column !== e.column) begin
          $error("column exp %0d got %0d", e.column, ray.column); fail_count++;
        end
        if (ray.wall_height !== e.wall_height) begin
          $error("wall_height exp %0d got %0d", e.wall_height, ray.wall_height); fail_count++;
        end
        if (ray.wall_top !== e.wall_top) begin
          $error("wall_top exp %0d got %0d", e.wall_top, ray.wall_top); fail_count++;
        end
        if (ray.distance !== e.distance) begin
          $error("distance exp %0d got %0d", e.distance, ray.distance); fail_count++;
        end
        if (ray.hit_x !== e.hit_x) begin
          $error("hit_x exp %0d got %0d", e.hit_x, ray.hit_x); fail_count++;
        end
        if (ray.hit_y !== e.hit_y) begin
          $error("hit_y exp %0d got %0d", e.hit_y, ray.hit_y); fail_count++;
        end
        if (ray.hit_vertical !== e.hit_vertical) begin
          $error("hit_vertical exp %0d got %0d", e.hit_vertical, ray.hit_vertical);
          fail_count++;
        end
        if (ray.no_hit !== e.no_hit) begin
          $error("no_hit exp %0d got %0d", e.no_hit, ray.no_hit); fail_count++;
        end
        if (ray.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, ray.last); fail_count++;
        end
      end
    end
  end

  task automatic test_default_map();
    logic [15:0] half;
    half = 16'((30 * 65536 + 180) / 360);
    send_frame(15'd0, 15'd0, 16'd0);
    send_frame(15'h7FFF, 15'h7FFF, 16'hFFFF);
    send_frame(15'd12288, 15'd12288, half);
    send_frame(15'd12288, 15'd12288, 16'(half + 16'd16384));
    send_frame(15'd16000, 15'd9000, 16'(half + 16'd32768));
    send_frame(15'd9000, 15'd16000, 16'(half + 16'd49152));
    send_frame(15'd8192, 15'd8192, 16'd8192);
    send_frame(15'd4096, 15'd20480, 16'd40000);
  endtask

  task automatic test_empty_map();
    write_map(64'd0);
    send_frame(15'd16384, 15'd16384, 16'd0);
    send_frame(15'd100, 15'd32000, 16'd20000);
  endtask

  task automatic test_full_map();
    write_map(64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(15'd16384, 15'd16384, 16'd0);
    send_frame(15'd4096, 15'd4096, 16'd30000);
    send_frame(15'h7FFF, 15'd0, 16'd50000);
  endtask

  task automatic test_single_tiles();
    write_map(64'd1);
    send_frame(15'd20000, 15'd20000, 16'd40960);
    write_map(64'h8000_0000_0000_0000);
    send_frame(15'd2000, 15'd2000, 16'd8192);
    send_frame(15'd30000, 15'd2000, 16'd16384);
  endtask

  task automatic test_random_frames();
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0) write_map(MAP_RESET);
      else if (phase % 3 == 0) write_map({$urandom, $urandom} & {$urandom, $urandom});
      else write_map({$urandom, $urandom});
      no_gaps = (phase == 4);
      for (int n = 0; n < 30; n++)
        send_frame(15'($urandom), 15'($urandom), 16'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    map_model = MAP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_map();
    test_empty_map();
    test_full_map();
    test_single_tiles();
    test_random_frames();
    frame.valid <= 1'b0;
    wait (column_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
design/grc_pkg.sv
design/grc_ifs.sv
design/grc_ctrl.sv
design/grc_datapath.sv
design/grid_raycast_column_heights_top.sv
bench/grid_raycast_column_heights_top_test.sv
